[hw/rtl/fbs_pkg.sv]
`default_nettype none
package fbs_pkg;

  localparam int FRAME_LENGTH = 263;
  localparam int GAP_COUNT    = 7;
  localparam int KEY_LEN      = 19;
  localparam int RUN_WRAP     = 20;
  localparam int RUN_START    = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] FILLER_BYTE = 8'h11;

  // register indexes on the configuration port
  localparam logic REG_KEY_EVEN = 1'b0;
  localparam logic REG_KEY_ODD  = 1'b1;

  typedef struct packed {
    logic [8:0] gap_pos;
    logic [2:0] gap_idx;
    logic       ins_done;
    logic [4:0] key_idx;
    logic [4:0] run_len;
    logic [8:0] frame_pos;
  } fbs_ctr_t;

  localparam fbs_ctr_t CTR_RESET = '{
    gap_pos:   9'd0,
    gap_idx:   3'd0,
    ins_done:  1'b0,
    key_idx:   5'd0,
    run_len:   5'(RUN_START),
    frame_pos: 9'd0
  };

  // one classified item handed from front to back
  typedef struct packed {
    logic       has_filler;
    logic [7:0] filler_byte;
    logic [7:0] data_byte;
  } fbs_entry_t;

  function automatic logic [8:0] fbs_gap(input logic [2:0] idx);
    logic [8:0] g;
    case (idx)
      3'd0:    g = 9'd0;
      3'd1:    g = 9'd4;
      3'd2:    g = 9'd8;
      3'd3:    g = 9'd24;
      3'd4:    g = 9'd80;
      3'd5:    g = 9'd60;
      3'd6:    g = 9'd44;
      default: g = 9'd0;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] fbs_seed(input logic [4:0] p);
    logic [7:0] s;
    case (p)
      5'd0:    s = 8'h13;
      5'd1:    s = 8'h60;
      5'd2:    s = 8'h86;
      5'd3:    s = 8'h9e;
      5'd4:    s = 8'hbf;
      5'd5:    s = 8'hde;
      5'd6:    s = 8'h11;
      5'd7:    s = 8'he5;
      5'd8:    s = 8'h9e;
      5'd9:    s = 8'he4;
      5'd10:   s = 8'hb8;
      5'd11:   s = 8'he8;
      5'd12:   s = 8'h56;
      5'd13:   s = 8'h2b;
      5'd14:   s = 8'h84;
      5'd15:   s = 8'hb4;
      5'd16:   s = 8'h16;
      5'd17:   s = 8'h18;
      5'd18:   s = 8'hf0;
      default: s = 8'h13;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] fbs_key(input logic [4:0] p, input logic [7:0] key_even,
                                         input logic [7:0] key_odd);
    return fbs_seed(p) ^ (p[0] ? key_odd : key_even);
  endfunction

  // advance keystream and frame counters by one output slot
  function automatic fbs_ctr_t fbs_advance(input fbs_ctr_t c);
    fbs_ctr_t n;
    n = c;
    n.key_idx = c.key_idx + 5'd1;
    if (n.key_idx >= c.run_len) begin
      n.key_idx = 5'd0;
      n.run_len = c.run_len + 5'd1;
      if (n.run_len >= 5'(RUN_WRAP)) begin
        n.run_len = 5'(RUN_START);
      end
    end
    n.frame_pos = c.frame_pos + 9'd1;
    if (n.frame_pos == 9'(FRAME_LENGTH)) begin
      n.frame_pos = 9'd0;
      n.gap_pos   = 9'd0;
      n.ins_done  = 1'b0;
    end else begin
      n.gap_pos = c.gap_pos + 9'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/fbs_if.sv]
`default_nettype none
interface fbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface fbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_filler;
  logic       last;

  modport source (output valid, output out_byte, output is_filler, output last, input ready);
  modport sink (input valid, input out_byte, input is_filler, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/fbs_front.sv]
`default_nettype none
module fbs_front
  import fbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  fbs_in_if.sink          in_ch,
  input  wire logic [7:0] key_even,
  input  wire logic [7:0] key_odd,
  input  wire logic       push_ready,
  output logic            push_valid,
  output fbs_entry_t      push_entry
);

  fbs_ctr_t ctr_r, ctr_nxt;
  fbs_ctr_t c0, c1, c2;
  logic     filler;

  always_comb begin
    c0 = in_ch.start_of_image ? CTR_RESET : ctr_r;
    if (c0.gap_idx >= 3'(GAP_COUNT)) begin
      c0.gap_idx = 3'd0;
    end
    filler = !c0.ins_done && (c0.gap_pos == fbs_gap(c0.gap_idx));

    c1 = c0;
    if (filler) begin
      c1.gap_idx = c0.gap_idx + 3'd1;
      if (c1.gap_idx >= 3'(GAP_COUNT)) begin
        c1.gap_idx  = 3'd0;
        c1.ins_done = 1'b1;
      end
      c1.gap_pos = 9'd0;
    end

    c2 = filler ? fbs_advance(c1) : c1;
    ctr_nxt = fbs_advance(c2);

    push_entry.has_filler  = filler;
    push_entry.filler_byte = FILLER_BYTE ^ fbs_key(c1.key_idx, key_even, key_odd);
    push_entry.data_byte   = in_ch.data_byte ^ fbs_key(c2.key_idx, key_even, key_odd);
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= CTR_RESET;
    end else if (in_ch.valid && push_ready) begin
      ctr_r <= ctr_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fbs_queue.sv]
`default_nettype none
module fbs_queue
  import fbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire fbs_entry_t push_entry,
  output logic      head_valid,
  output fbs_entry_t head_entry,
  input  wire logic pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  fbs_entry_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fbs_back.sv]
`default_nettype none
module fbs_back
  import fbs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire fbs_entry_t head_entry,
  output logic       pop,
  fbs_out_if.source  out_ch
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       is_filler_r;
  logic       last_r;
  logic       phase_r, phase_nxt;
  logic       load, send_filler;

  assign load        = (!out_valid_r || out_ch.ready) && head_valid;
  assign send_filler = head_entry.has_filler && !phase_r;
  assign pop         = load && !send_filler;

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = send_filler;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // register the next output byte; the filler's entry stays at the head until its data byte goes out
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= send_filler ? head_entry.filler_byte : head_entry.data_byte;
      is_filler_r <= send_filler;
      last_r      <= !send_filler;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.is_filler = is_filler_r;
  assign out_ch.last      = last_r;

`ifndef SYNTHESIS
  a_filler_xor_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (is_filler_r != last_r))
    else $error("filler and last flags disagree");

  a_data_after_filler: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && is_filler_r) |=> (out_valid_r && last_r))
    else $error("data byte did not follow its filler");

  a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid && head_entry.has_filler))
    else $error("filler phase without a filler entry at the head");
`endif

endmodule
`default_nettype wire

[hw/rtl/firmware_byte_scrambler.sv]
`default_nettype none
// Firmware byte scrambler. Takes one image byte per transfer and returns one or two
// scrambled bytes: an optional 0x11 filler (is_filler set) followed by the data byte
// (last set), each XORed with the keystream built from key_even and key_odd. The front
// end classifies and scrambles each byte in the cycle it is accepted, so inputs are taken
// one per cycle while the queue has room; a byte that carries a filler yields two output
// bytes and the two-entry queue between front and back then back-pressures the input.
// Results pass the queue and an output register. Write key_even (address 0) and key_odd
// (address 4) only while the stream is idle.
module firmware_byte_scrambler
  import fbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  fbs_in_if.sink           in_ch,
  fbs_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0] key_even_r, key_odd_r;
  logic       push_valid, push_ready, head_valid, pop;
  fbs_entry_t push_entry, head_entry;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_even_r <= '0;
      key_odd_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_KEY_EVEN: key_even_r <= pwdata[7:0];
        REG_KEY_ODD:  key_odd_r  <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KEY_EVEN: prdata = {24'd0, key_even_r};
      REG_KEY_ODD:  prdata = {24'd0, key_odd_r};
      default:      prdata = '0;
    endcase
  end

  fbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .key_even   (key_even_r),
    .key_odd    (key_odd_r),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  fbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  fbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } image_byte_t;

  typedef struct packed {
    logic [7:0] value;
    logic       filler;
    logic       last;
  } scrambled_t;

  typedef struct {
    logic [8:0] gap_pos;
    logic [2:0] gap_idx;
    logic       ins_done;
    logic [4:0] key_idx;
    logic [4:0] run_len;
    logic [8:0] frame_pos;
  } scrambler_state_t;

  // gap entry i sits at bits 9*i, seed byte p at bits 8*p
  localparam logic [GAP_COUNT*9-1:0] GAP_STEPS = {
    9'd44, 9'd60, 9'd80, 9'd24, 9'd8, 9'd4, 9'd0
  };
  localparam logic [KEY_LEN*8-1:0] SEED_BYTES = {
    8'hf0, 8'h18, 8'h16, 8'hb4, 8'h84, 8'h2b, 8'h56, 8'he8, 8'hb8, 8'he4,
    8'h9e, 8'he5, 8'h11, 8'hde, 8'hbf, 8'h9e, 8'h86, 8'h60, 8'h13
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fbs_in_if  byte_in ();
  fbs_out_if byte_out ();

  firmware_byte_scrambler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (byte_in),
    .out_ch  (byte_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  image_byte_t      pending_q[$];
  scrambled_t       scrambled_q[$];
  scrambler_state_t sst;
  logic [7:0]       key_even_q;
  logic [7:0]       key_odd_q;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int hold_requests  = 0;
  int holds_taken    = 0;
  int errors         = 0;

  function automatic scrambler_state_t fresh_state();
    scrambler_state_t s;
    s.gap_pos   = 9'd0;
    s.gap_idx   = 3'd0;
    s.ins_done  = 1'b0;
    s.key_idx   = 5'd0;
    s.run_len   = 5'(RUN_START);
    s.frame_pos = 9'd0;
    return s;
  endfunction

  function automatic logic [7:0] keystream(input logic [4:0] p);
    logic [7:0] k;
    k = p[0] ? key_odd_q : key_even_q;
    return SEED_BYTES[int'(p)*8 +: 8] ^ k;
  endfunction

  // scramble one output slot, then advance keystream and frame counters
  task automatic put_scrambled(input logic [7:0] b, input logic filler, input logic last);
    scrambled_t r;
    r.value  = b ^ keystream(sst.key_idx);
    r.filler = filler;
    r.last   = last;
    scrambled_q.push_back(r);
    sst.key_idx = sst.key_idx + 5'd1;
    if (sst.key_idx >= sst.run_len) begin
      sst.key_idx = 5'd0;
      sst.run_len = sst.run_len + 5'd1;
      if (sst.run_len >= 5'(RUN_WRAP)) begin
        sst.run_len = 5'(RUN_START);
      end
    end
    sst.frame_pos = sst.frame_pos + 9'd1;
    if (sst.frame_pos == 9'(FRAME_LENGTH)) begin
      sst.frame_pos = 9'd0;
      sst.gap_pos   = 9'd0;
      sst.ins_done  = 1'b0;
    end else begin
      sst.gap_pos = sst.gap_pos + 9'd1;
    end
  endtask

  task automatic predict_item(input image_byte_t it);
    if (it.sof) begin
      sst = fresh_state();
    end
    if (sst.gap_idx >= 3'(GAP_COUNT)) begin
      sst.gap_idx = 3'd0;
    end
    if (!sst.ins_done && sst.gap_pos == GAP_STEPS[int'(sst.gap_idx)*9 +: 9]) begin
      sst.gap_idx = sst.gap_idx + 3'd1;
      if (sst.gap_idx >= 3'(GAP_COUNT)) begin
        sst.gap_idx  = 3'd0;
        sst.ins_done = 1'b1;
      end
      sst.gap_pos = 9'd0;
      put_scrambled(FILLER_BYTE, 1'b1, 1'b0);
    end
    put_scrambled(it.data, 1'b0, 1'b1);
  endtask

  // input driver: predict on each transfer, then offer the next byte or idle
  always @(posedge clk) begin : drive
    image_byte_t took;
    image_byte_t nxt;
    if (!rst_n) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        took.data = byte_in.data_byte;
        took.sof  = byte_in.start_of_image;
        predict_item(took);
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          byte_in.valid          <= 1'b1;
          byte_in.data_byte      <= nxt.data;
          byte_in.start_of_image <= nxt.sof;
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, one per request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_taken != hold_requests) begin
      hold_left   <= 80;
      holds_taken <= holds_taken + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    scrambled_t want;
    if (!rst_n) begin
      byte_out.ready <= 1'b0;
    end else begin
      byte_out.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (byte_out.valid && byte_out.ready) begin
        if (scrambled_q.size() == 0) begin
          $error("unexpected result: out_byte %h is_filler %b last %b",
                 byte_out.out_byte, byte_out.is_filler, byte_out.last);
          errors = errors + 1;
        end else begin
          want = scrambled_q.pop_front();
          if (byte_out.out_byte !== want.value) begin
            $error("out_byte: expected %h, actual %h", want.value, byte_out.out_byte);
            errors = errors + 1;
          end
          if (byte_out.is_filler !== want.filler) begin
            $error("is_filler: expected %b, actual %b", want.filler, byte_out.is_filler);
            errors = errors + 1;
          end
          if (byte_out.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, byte_out.last);
            errors = errors + 1;
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic s);
    image_byte_t it;
    it.data = d;
    it.sof  = s;
    pending_q.push_back(it);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_KEY_EVEN) begin
      key_even_q = v;
    end else begin
      key_odd_q = v;
    end
  endtask

  // mostly whole images opened by the start flag; some carry on the stream, a few
  // carry a stray start flag mid-image
  task automatic queue_images(input int n);
    int  k;
    int  len;
    bit  fresh;
    k = 0;
    while (k < n) begin
      len   = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : $urandom_range(40, 700);
      fresh = ($urandom_range(9) != 0);
      for (int i = 0; i < len && k < n; i++) begin
        push_byte(8'($urandom), (i == 0 && fresh) || $urandom_range(149) == 0);
        k++;
      end
    end
  endtask

  task automatic run_phase(input bit write_keys, input logic [7:0] ke, input logic [7:0] ko,
                           input int send_pct, input int recv_pct, input int n_rand,
                           input bit burst);
    if (write_keys) begin
      write_reg(REG_KEY_EVEN, ke);
      write_reg(REG_KEY_ODD, ko);
    end
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_images(n_rand);
    if (burst) begin
      @(posedge clk);
      hold_requests <= hold_requests + 1;
    end
    do @(negedge clk); while (pending_q.size() != 0 || byte_in.valid || scrambled_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : sequencer
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    byte_in.valid          = 1'b0;
    byte_in.data_byte      = '0;
    byte_in.start_of_image = 1'b0;
    byte_out.ready         = 1'b0;
    sst                    = fresh_state();
    key_even_q             = 8'h00;
    key_odd_q              = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes, filler-valued data, start flag mid-stream and three times running
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b0);
    push_byte(8'hfe, 1'b0);
    push_byte(8'h3c, 1'b1);
    push_byte(8'hc3, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h0f, 1'b0);
    push_byte(8'hf0, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h96, 1'b0);
    push_byte(8'h69, 1'b1);
    push_byte(8'h5a, 1'b0);
    push_byte(8'ha5, 1'b0);

    run_phase(1'b0, 8'h00, 8'h00, 0, 0, 150, 1'b1);
    run_phase(1'b1, 8'hff, 8'hff, 70, 0, 200, 1'b0);
    run_phase(1'b1, 8'h00, 8'hff, 0, 70, 200, 1'b0);
    run_phase(1'b1, 8'($urandom), 8'($urandom), 8, 8, 200, 1'b1);
    run_phase(1'b1, 8'hff, 8'h00, 0, 0, 200, 1'b0);

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
